// ----- rtl/rgbcv_pkg.sv -----
// Package: shared types and constants for the RGBA 3x3 convolution stream.
`default_nettype none

package rgbcv_pkg;

  localparam int PIX_W          = 24;  // R, G, B bytes of one pixel
  localparam int CH_W           = 8;
  localparam int TAP_W          = 16;  // Q4.12 kernel tap
  localparam int KERN_W         = 3 * TAP_W;
  localparam int PROD_W         = TAP_W + CH_W + 1;
  localparam int RSUM_W         = PROD_W + 2;
  localparam int SUM_W          = RSUM_W + 2;
  localparam int COEF_FRAC_BITS = 12;
  localparam int COL_W          = 10;
  localparam int ROW_W          = 12;
  localparam int FW_W           = 11;
  localparam int FH_W           = 13;
  localparam int CFG_IDX_W      = 3;
  localparam int ROW_LIMIT      = 4096;
  localparam int COL_LIMIT      = 1024;

  localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_KERN_LOW     = 3'd2,
    CFG_KERN_MID     = 3'd3,
    CFG_KERN_HIGH    = 3'd4
  } cfg_idx_e;

  typedef logic [PIX_W-1:0] pix_t;

  // window row 0 is two rows up, column 0 is the oldest pixel
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;
  typedef logic [2:0][KERN_W-1:0] kern_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } tag_t;

endpackage

`default_nettype wire

// ----- rtl/rgbcv_filter.sv -----
// Kernel datapath: products, row sums, final sum with floor and clamp, output register.
`default_nettype none

module rgbcv_filter (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  rgbcv_pkg::tag_t      in_tag_i,
  input  rgbcv_pkg::win_t      win_i,
  input  rgbcv_pkg::kern_t     kern_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output rgbcv_pkg::tag_t      out_tag_o,
  output rgbcv_pkg::pix_t      out_rgb_o
);
  import rgbcv_pkg::*;

  logic en_c, en_d, en_o;
  logic c_v_q, d_v_q, o_v_q;
  tag_t c_tag_q, d_tag_q, o_tag_q;

  logic signed [PROD_W-1:0] prod_d [3][3][3];
  logic signed [PROD_W-1:0] prod_q [3][3][3];
  logic signed [RSUM_W-1:0] rsum_d [3][3];
  logic signed [RSUM_W-1:0] rsum_q [3][3];
  logic signed [SUM_W-1:0]  tot    [3];
  logic        [SUM_W-1:0]  shf    [3];
  pix_t                     rgb_d, o_rgb_q;

  always_comb begin
    en_o       = !o_v_q || out_ready_i;
    en_d       = !d_v_q || en_o;
    en_c       = !c_v_q || en_d;
    in_ready_o = en_c;
  end

  // products: channel x kernel row x kernel column
  always_comb begin
    logic signed [PROD_W-1:0] ta, px;
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          ta = {{(PROD_W-TAP_W){kern_i[r][k*TAP_W+TAP_W-1]}}, kern_i[r][k*TAP_W +: TAP_W]};
          px = {{(PROD_W-CH_W){1'b0}}, win_i[r][k][ch*CH_W +: CH_W]};
          prod_d[ch][r][k] = ta * px;
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        rsum_d[ch][r] = RSUM_W'(prod_q[ch][r][0]) + RSUM_W'(prod_q[ch][r][1])
                      + RSUM_W'(prod_q[ch][r][2]);
      end
    end
  end

  // negative sums give 0, otherwise floor to bytes and saturate
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      tot[ch] = SUM_W'(rsum_q[ch][0]) + SUM_W'(rsum_q[ch][1]) + SUM_W'(rsum_q[ch][2]);
      shf[ch] = SUM_W'(tot[ch]) >> COEF_FRAC_BITS;
      if (tot[ch][SUM_W-1]) begin
        rgb_d[ch*CH_W +: CH_W] = '0;
      end else if (shf[ch] > SUM_W'(255)) begin
        rgb_d[ch*CH_W +: CH_W] = 8'hFF;
      end else begin
        rgb_d[ch*CH_W +: CH_W] = shf[ch][CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      if (en_c) c_v_q <= in_valid_i;
      if (en_d) d_v_q <= c_v_q;
      if (en_o) o_v_q <= d_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_c && in_valid_i) begin
      c_tag_q <= in_tag_i;
      prod_q  <= prod_d;
    end
    if (en_d && c_v_q) begin
      d_tag_q <= c_tag_q;
      rsum_q  <= rsum_d;
    end
    if (en_o && d_v_q) begin
      o_tag_q <= d_tag_q;
      o_rgb_q <= rgb_d;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_tag_o   = o_tag_q;
  assign out_rgb_o   = o_rgb_q;

  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !o_v_q |-> in_ready_o)
    else $error("filter refuses input with an empty output register");

  a_stall_keeps_c: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_v_q && !en_d) |=> c_v_q)
    else $error("product stage dropped a stalled item");

  a_interior_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_tag_o.col != '0 && out_tag_o.row != '0))
    else $error("result tagged with a border position");

endmodule

`default_nettype wire

// ----- rtl/rgba_conv3x3_stream_top.sv -----
// Top level: position counters, line store memory, 3x3 window and configuration registers.
//
//  port group | dir | word                         | handshake
//  s_axis     | in  | tdata[31:0] pixel, tuser SOF | tvalid/tready
//  m_axis     | out | tdata pixel, col, row; tlast | tvalid/tready
//  cfg        | in  | cfg_idx_i, cfg_data_i        | cfg_we_i, no wait
//
// One word per clock sustained while m_axis_tready stays high.
// The line store is one memory holding both previous rows per column: read at
// acceptance, written back one stage later, with a forward path for a repeated column.
// Reset clears counters, window and stage valids; the memory is not cleared.
// A stall on m_axis fills the 5 stages before s_axis_tready drops.
`default_nettype none

module rgba_conv3x3_stream_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [31:0]                   s_axis_tdata,  // in_pixel
  input  wire logic [0:0]                    s_axis_tuser,  // start_of_frame
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [55:0]                        m_axis_tdata,  // out_pixel, out_col, out_row
  output logic                               m_axis_tlast,  // frame_done
  input  wire logic                          cfg_we_i,
  input  wire logic [rgbcv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [rgbcv_pkg::KERN_W-1:0]  cfg_data_i
);
  import rgbcv_pkg::*;

  localparam int IDX_W   = $clog2(MAX_WIDTH);
  localparam int COL_MAX = (MAX_WIDTH < COL_LIMIT) ? MAX_WIDTH : COL_LIMIT;

  // configuration
  logic [FW_W-1:0] fw_q;
  logic [FH_W-1:0] fh_q;
  kern_t           kern_q;
  logic [FW_W-1:0] w_eff;
  logic [FH_W-1:0] h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= FW_W'(640);
      fh_q   <= FH_W'(480);
      kern_q <= {48'd0, 48'h0000_1000_0000, 48'd4096};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_q      <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT: fh_q      <= cfg_data_i[FH_W-1:0];
        CFG_KERN_LOW:     kern_q[0] <= cfg_data_i;
        CFG_KERN_MID:     kern_q[1] <= cfg_data_i;
        CFG_KERN_HIGH:    kern_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (fw_q < FW_W'(3))            w_eff = FW_W'(3);
    else if (fw_q > FW_W'(COL_MAX)) w_eff = FW_W'(COL_MAX);
    else                            w_eff = fw_q;
    if (fh_q < FH_W'(3))              h_eff = FH_W'(3);
    else if (fh_q > FH_W'(ROW_LIMIT)) h_eff = FH_W'(ROW_LIMIT);
    else                              h_eff = fh_q;
  end

  // stage handshake
  logic en_a, en_b, acc, mv_ab, flt_ready;
  logic a_v_q, b_v_q;

  assign en_b          = !b_v_q || flt_ready;
  assign en_a          = !a_v_q || en_b;
  assign acc           = s_axis_tvalid && en_a;
  assign mv_ab         = a_v_q && en_b;
  assign s_axis_tready = en_a;

  // position of the incoming word
  logic [COL_W-1:0] col_q, col_d, c_cur;
  logic [ROW_W-1:0] row_q, row_d, r_cur;
  logic [IDX_W-1:0] idx_q, idx_d, idx_cur;
  logic [FW_W-1:0]  c_inc;
  logic [FH_W-1:0]  r_inc;
  logic             res_cur;
  tag_t             tag_cur;

  always_comb begin
    c_cur   = s_axis_tuser[0] ? '0 : col_q;
    r_cur   = s_axis_tuser[0] ? '0 : row_q;
    idx_cur = s_axis_tuser[0] ? '0 : idx_q;
    res_cur = (c_cur >= COL_W'(2)) && ({1'b0, c_cur} < w_eff)
           && (r_cur >= ROW_W'(2)) && ({1'b0, r_cur} < h_eff);
    tag_cur.col  = c_cur - COL_W'(1);
    tag_cur.row  = r_cur - ROW_W'(1);
    tag_cur.last = ({1'b0, c_cur} == w_eff - FW_W'(1))
                && ({1'b0, r_cur} == h_eff - FH_W'(1));
    c_inc = {1'b0, c_cur} + FW_W'(1);
    r_inc = {1'b0, r_cur} + FH_W'(1);
    if (c_inc >= w_eff) begin
      col_d = '0;
      idx_d = '0;
      row_d = (r_inc >= h_eff) ? '0 : r_inc[ROW_W-1:0];
    end else begin
      col_d = c_inc[COL_W-1:0];
      idx_d = (idx_cur == IDX_W'(MAX_WIDTH - 1)) ? '0 : idx_cur + IDX_W'(1);
      row_d = r_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      idx_q <= '0;
    end else if (acc) begin
      col_q <= col_d;
      row_q <= row_d;
      idx_q <= idx_d;
    end
  end

  // line store: entry is {row two up, row one up}
  logic [2*PIX_W-1:0] line_mem_q [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q, rd_eff, wr_data, a_fwd_q;
  logic [IDX_W-1:0]   a_idx_q;
  pix_t               a_pix_q;
  logic               a_hit_q, a_res_q, b_res_q;
  tag_t               a_tag_q, b_tag_q;
  win_t               win_q;

  assign rd_eff  = a_hit_q ? a_fwd_q : rd_q;
  assign wr_data = {rd_eff[PIX_W-1:0], a_pix_q};

  always_ff @(posedge clk_i) begin
    if (mv_ab) line_mem_q[a_idx_q] <= wr_data;
    if (acc)   rd_q <= line_mem_q[idx_cur];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      if (en_a) a_v_q <= s_axis_tvalid;
      if (en_b) b_v_q <= a_v_q;
    end
  end

  // same column written back in this cycle: take the write data instead
  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_idx_q <= idx_cur;
      a_pix_q <= s_axis_tdata[PIX_W-1:0];
      a_res_q <= res_cur;
      a_tag_q <= tag_cur;
      a_hit_q <= mv_ab && (a_idx_q == idx_cur);
      a_fwd_q <= wr_data;
    end
    if (mv_ab) begin
      b_res_q <= a_res_q;
      b_tag_q <= a_tag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (mv_ab) begin
      for (int k = 0; k < 3; k++) begin
        win_q[k][0] <= win_q[k][1];
        win_q[k][1] <= win_q[k][2];
      end
      win_q[0][2] <= rd_eff[2*PIX_W-1:PIX_W];
      win_q[1][2] <= rd_eff[PIX_W-1:0];
      win_q[2][2] <= a_pix_q;
    end
  end

  tag_t out_tag;
  pix_t out_rgb;

  rgbcv_filter u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (b_v_q && b_res_q),
    .in_tag_i    (b_tag_q),
    .win_i       (win_q),
    .kern_i      (kern_q),
    .in_ready_o  (flt_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_tag_o   (out_tag),
    .out_rgb_o   (out_rgb)
  );

  assign m_axis_tdata = {2'b00, out_tag.row, out_tag.col, ALPHA_OPAQUE, out_rgb};
  assign m_axis_tlast = out_tag.last;

  a_ready_with_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!a_v_q || !b_v_q) |-> s_axis_tready)
    else $error("input stalled with a free stage");

  a_ab_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv_ab |=> b_v_q)
    else $error("word lost between read and window stage");

  a_idx_follows_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q == '0) |-> (idx_q == '0))
    else $error("line store index out of step with column");

endmodule

`default_nettype wire

// ----- bench/rgba_conv3x3_stream_checker.sv -----
`timescale 1ns / 100ps
// Checker: predicts the filtered pixels from the input stream and compares them with the output.
module rgba_conv3x3_stream_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,  // in_pixel
  input  logic [0:0]                      s_axis_tuser,  // start_of_frame
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [55:0]                     m_axis_tdata,  // out_pixel, out_col, out_row
  input  logic                            m_axis_tlast,  // frame_done
  input  logic                            cfg_we_i,
  input  logic [rgbcv_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rgbcv_pkg::KERN_W-1:0]    cfg_data_i,
  output int                              mismatches_o,
  output int                              pending_o
);
  import rgbcv_pkg::*;

  typedef struct packed {
    logic [31:0]      rgba;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } filt_px_t;

  filt_px_t          filtered_q[$];
  pix_t              line_prev [COL_LIMIT];
  pix_t              line_prev2[COL_LIMIT];
  pix_t              win[3][3];  // [row][col]: row 0 is v-1, col 0 the oldest pixel
  logic [FW_W-1:0]   width_reg;
  logic [FH_W-1:0]   height_reg;
  logic [KERN_W-1:0] kern[3];    // kern[0] weights row v-1, kern[2] row v+1
  logic [COL_W-1:0]  next_col;
  logic [ROW_W-1:0]  next_row;

  function automatic logic [CH_W-1:0] filter_channel(input int lsb);
    longint                  acc;
    logic signed [TAP_W-1:0] tap;
    acc = 0;
    for (int r = 0; r < 3; r++)
      for (int k = 0; k < 3; k++) begin
        tap = kern[r][TAP_W*k +: TAP_W];
        acc += longint'(tap) * longint'(win[r][k][lsb +: CH_W]);
      end
    if (acc < 0) return '0;
    acc = acc >>> COEF_FRAC_BITS;
    return (acc > 255) ? 8'hFF : acc[CH_W-1:0];
  endfunction

  task automatic convolve_pixel(input logic [31:0] word, input logic sof);
    int       w, h, c, r;
    pix_t     above, above2;
    filt_px_t res;
    w = (width_reg < 3) ? 3 : (width_reg > COL_LIMIT) ? COL_LIMIT : int'(width_reg);
    h = (height_reg < 3) ? 3 : (height_reg > ROW_LIMIT) ? ROW_LIMIT : int'(height_reg);
    c = sof ? 0 : int'(next_col);
    r = sof ? 0 : int'(next_row);
    above  = line_prev[c];
    above2 = line_prev2[c];
    line_prev2[c] = above;
    line_prev[c]  = word[PIX_W-1:0];
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = above2;
    win[1][2] = above;
    win[2][2] = word[PIX_W-1:0];
    // only interior centers produce a word
    if (c >= 2 && c < w && r >= 2 && r < h) begin
      res.rgba = {ALPHA_OPAQUE, filter_channel(16), filter_channel(8), filter_channel(0)};
      res.col  = COL_W'(c - 1);
      res.row  = ROW_W'(r - 1);
      res.last = (c == w - 1) && (r == h - 1);
      filtered_q.push_back(res);
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_col = COL_W'(c);
    next_row = ROW_W'(r);
  endtask

  task automatic check_result();
    filt_px_t got, want;
    got.rgba = m_axis_tdata[31:0];
    got.col  = m_axis_tdata[32 +: COL_W];
    got.row  = m_axis_tdata[32 + COL_W +: ROW_W];
    got.last = m_axis_tlast;
    if (filtered_q.size() == 0) begin
      $display("%0t: expected no word, got pixel %h col %0d row %0d last %b",
               $time, got.rgba, got.col, got.row, got.last);
      mismatches_o++;
      return;
    end
    want = filtered_q.pop_front();
    if (got.rgba !== want.rgba) begin
      $display("%0t: out_pixel expected %h got %h", $time, want.rgba, got.rgba);
      mismatches_o++;
    end
    if (got.col !== want.col) begin
      $display("%0t: out_col expected %0d got %0d", $time, want.col, got.col);
      mismatches_o++;
    end
    if (got.row !== want.row) begin
      $display("%0t: out_row expected %0d got %0d", $time, want.row, got.row);
      mismatches_o++;
    end
    if (got.last !== want.last) begin
      $display("%0t: frame_done expected %b got %b", $time, want.last, got.last);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg    = FW_W'(640);
      height_reg   = FH_W'(480);
      kern[0]      = KERN_W'(48'h0000_0000_1000);
      kern[1]      = KERN_W'(48'h0000_1000_0000);
      kern[2]      = '0;
      win          = '{default: '0};
      next_col     = '0;
      next_row     = '0;
      mismatches_o = 0;
      filtered_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FRAME_WIDTH:  width_reg  = cfg_data_i[FW_W-1:0];
          CFG_FRAME_HEIGHT: height_reg = cfg_data_i[FH_W-1:0];
          CFG_KERN_LOW:     kern[0]    = cfg_data_i;
          CFG_KERN_MID:     kern[1]    = cfg_data_i;
          CFG_KERN_HIGH:    kern[2]    = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) convolve_pixel(s_axis_tdata, s_axis_tuser[0]);
      if (m_axis_tvalid && m_axis_tready) check_result();
    end
    pending_o = filtered_q.size();
  end

endmodule

// ----- bench/rgba_conv3x3_stream_top_test.sv -----
`timescale 1ns / 100ps
// Testbench top: clock, reset, stimulus with idling phases and the final verdict.
module rgba_conv3x3_stream_top_test;
  import rgbcv_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 12;  // margin after the last expected word, left for stalled stages
  localparam logic [31:0] PROBE_FRAME [9] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_FFFF,
    32'hFF00_0000, 32'h3C80_FF01, 32'h00FF_0000,
    32'h0000_FF00, 32'h0000_00FF, 32'hFFFF_FFFF
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata;  // in_pixel
  logic [0:0]           s_axis_tuser;  // start_of_frame
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [55:0]          m_axis_tdata;  // out_pixel, out_col, out_row
  logic                 m_axis_tlast;  // frame_done
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [KERN_W-1:0]    cfg_data_i;

  int   mismatches;
  int   pending;
  int   src_idle_pct;
  int   sink_stall_pct;
  int   cur_width;
  int   cur_height;
  logic need_start;

  rgba_conv3x3_stream_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  rgba_conv3x3_stream_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // output side back-pressure
  always @(negedge clk_i) m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

  function automatic int eff_width(input int unsigned w_reg);
    return (w_reg < 3) ? 3 : (w_reg > COL_LIMIT) ? COL_LIMIT : int'(w_reg);
  endfunction

  function automatic int eff_height(input int unsigned h_reg);
    return (h_reg < 3) ? 3 : (h_reg > ROW_LIMIT) ? ROW_LIMIT : int'(h_reg);
  endfunction

  function automatic logic [KERN_W-1:0] random_taps();
    logic [KERN_W-1:0] taps;
    int                pick;
    for (int k = 0; k < 3; k++) begin
      pick = $urandom_range(99);
      if (pick < 55)      taps[TAP_W*k +: TAP_W] = TAP_W'(int'($urandom_range(3000)) - 1200);
      else if (pick < 75) taps[TAP_W*k +: TAP_W] = TAP_W'($urandom());
      else if (pick < 85) taps[TAP_W*k +: TAP_W] = 16'h8000;
      else if (pick < 95) taps[TAP_W*k +: TAP_W] = 16'h7FFF;
      else                taps[TAP_W*k +: TAP_W] = '0;
    end
    return taps;
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [KERN_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
  endtask

  // A wider frame leaves line store columns unfilled, so restart at (0, 0) after widening.
  task automatic apply_settings(input int unsigned w_reg, input int unsigned h_reg,
                                input logic [KERN_W-1:0] k_low, input logic [KERN_W-1:0] k_mid,
                                input logic [KERN_W-1:0] k_high);
    if (eff_width(w_reg) > cur_width) need_start = 1'b1;
    cur_width  = eff_width(w_reg);
    cur_height = eff_height(h_reg);
    write_reg(CFG_FRAME_WIDTH, KERN_W'(w_reg));
    write_reg(CFG_FRAME_HEIGHT, KERN_W'(h_reg));
    write_reg(CFG_KERN_LOW, k_low);
    write_reg(CFG_KERN_MID, k_mid);
    write_reg(CFG_KERN_HIGH, k_high);
    cfg_we_i <= 1'b0;
  endtask

  task automatic put_word(input logic [31:0] pix, input logic sof);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= sof | need_start;
    need_start = 1'b0;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    sink_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Mostly runs of whole rows; some cut short by a new start mark, some running on unmarked.
  task automatic random_frames(input int quota);
    int   sent, n, kind, rows;
    logic mark;
    sent = 0;
    while (sent < quota) begin
      kind = $urandom_range(99);
      rows = (cur_height > 8) ? int'($urandom_range(8, 3)) : cur_height;
      mark = 1'b1;
      if (kind < 70) begin
        n = cur_width * rows;
      end else if (kind < 85) begin
        n = $urandom_range(cur_width * rows - 1, 1);
      end else begin
        n = $urandom_range(2 * cur_width, 1);
        mark = 1'b0;
      end
      for (int i = 0; i < n; i++) put_word($urandom(), mark && i == 0);
      sent += n;
    end
  endtask

  initial begin
    int unsigned      w_reg, h_reg;
    int               pick;
    logic [KERN_W-1:0] k_low, k_mid, k_high;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_FRAME_WIDTH;
    cfg_data_i     = '0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    cur_width      = 640;
    cur_height     = 480;
    need_start     = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // three rows of a narrow frame under the power-up kernel
    write_reg(CFG_FRAME_WIDTH, KERN_W'(10));
    cfg_we_i <= 1'b0;
    cur_width = 10;
    for (int i = 0; i < 10 * 3; i++) put_word($urandom(), i == 0);
    drain();

    // identity kernel, clamped 3x3 frame, preceded by a frame cut short
    apply_settings(0, 0, '0, 48'h0000_1000_0000, '0);
    put_word($urandom(), 1'b1);
    put_word($urandom(), 1'b0);
    for (int i = 0; i < 9; i++) put_word(PROBE_FRAME[i], i == 0);
    drain();

    // extreme taps; narrow the frame while the column is beyond the new width
    apply_settings(6, 4, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h0001_7FFF_8000);
    for (int i = 0; i < 10; i++) put_word($urandom_range(1) ? 32'hFFFF_FFFF : 32'h0, i == 0);
    drain();
    apply_settings(3, 4, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h0001_7FFF_8000);
    for (int i = 0; i < 7; i++) put_word($urandom_range(1) ? 32'hFFFF_FFFF : $urandom(), 1'b0);
    drain();

    for (int p = 0; p < 8; p++) begin
      pick  = $urandom_range(99);
      w_reg = (pick < 15) ? $urandom_range(2) : $urandom_range(12, 3);
      pick  = $urandom_range(99);
      h_reg = (pick < 10) ? $urandom_range(2)
            : (pick < 20) ? $urandom_range(8191, 13) : $urandom_range(8, 3);
      k_low  = random_taps();
      k_mid  = random_taps();
      k_high = random_taps();
      apply_settings(w_reg, h_reg, k_low, k_mid, k_high);
      case (p % 4)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 88;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 88;
        end
        default: begin
          src_idle_pct   = 30;
          sink_stall_pct = 30;
        end
      endcase
      random_frames(70);
      drain();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
